[hw/rtl/tpps_pkg.sv]
// ----------------------------------------------------------------------------
// Torus point projector and shader: shared types and constants
// Q1.15 trig types, the configuration register map and the Q15 multiply
// used by the rotation and shading stages.
// ----------------------------------------------------------------------------
package tpps_pkg;

    // Q1.15 sine/cosine, and a wider form for sums of two Q15 products
    typedef logic signed [15:0] q15_t;
    typedef logic signed [17:0] q15w_t;

    typedef struct packed {
        q15_t sin_theta;
        q15_t cos_theta;
        q15_t sin_phi;
        q15_t cos_phi;
        q15_t sin_a;
        q15_t cos_a;
        q15_t sin_b;
        q15_t cos_b;
    } trig_t;

    typedef enum logic [2:0] {
        CFG_ANGLE_A,
        CFG_ANGLE_B,
        CFG_TUBE_RADIUS,
        CFG_RING_RADIUS,
        CFG_VIEWER_DIST,
        CFG_PROJ_SCALE,
        CFG_CENTER_COL,
        CFG_CENTER_ROW
    } cfg_idx_t;

    localparam int TUBE_W   = 3;
    localparam int RING_W   = 4;
    localparam int VIEW_W   = 6;
    localparam int SCALE_W  = 8;
    localparam int CENTER_W = 7;
    localparam int GLYPH_W  = 4;

    localparam logic [TUBE_W-1:0]   TUBE_RESET   = 3'd1;
    localparam logic [RING_W-1:0]   RING_RESET   = 4'd2;
    localparam logic [VIEW_W-1:0]   VIEW_RESET   = 6'd5;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd30;
    localparam logic [CENTER_W-1:0] CCOL_RESET   = 7'd40;
    localparam logic [CENTER_W-1:0] CROW_RESET   = 7'd30;

    localparam int                  LIGHT_SHIFT  = 3;
    localparam logic [GLYPH_W-1:0]  GLYPH_MAX    = 4'd11;
    localparam longint unsigned     HALF_PI_Q30  = 64'd1686629713;

    // Q15 x Q15 -> Q15, truncated toward zero
    function automatic q15w_t mul_q15(input q15w_t a, input q15w_t b);
        logic signed [35:0] p;
        logic signed [35:0] r;
        p = a * b;
        r = (p + (p[35] ? 36'sd32767 : 36'sd0)) >>> 15;
        return r[17:0];
    endfunction

endpackage

[hw/rtl/torus_point_project_shade.sv]
// ----------------------------------------------------------------------------
// Torus point projector and shader
// Rotates one torus surface sample by the frame angles, projects it onto the
// screen grid and shades it to a glyph index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one (theta, phi) sample per transfer. Result channel
//   m_*: column, row, glyph_index and plotted, exactly one per sample, in
//   order. Registers are written through cfg_wr_en/cfg_index/cfg_data; the
//   user writes them only while no sample is in flight (block does not enforce).
//   The pipeline has one table stage, three rotation/shading stages, two
//   projection stages and one divider stage per quotient bit. Throughput
//   is one sample per cycle unless a result waits on the receiver; every
//   stage is a register stage with a single shared advance enable.
//   When the receiver stalls, the whole pipeline holds and s_ready drops
//   until the output register is taken; nothing is lost or repeated.
//   Reset clears the in-flight valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module torus_point_project_shade #(
    parameter int GRID_SIZE     = 100,
    parameter int ANGLE_BITS    = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ANGLE_BITS-1:0]               s_theta,
    input  logic [ANGLE_BITS-1:0]               s_phi,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [$clog2(GRID_SIZE)-1:0]        m_column,
    output logic [$clog2(GRID_SIZE)-1:0]        m_row,
    output logic [tpps_pkg::GLYPH_W-1:0]        m_glyph_index,
    output logic                                m_plotted,
    input  logic                                cfg_wr_en,
    input  tpps_pkg::cfg_idx_t                  cfg_index,
    input  logic [ANGLE_BITS-1:0]               cfg_data
);
    import tpps_pkg::*;

    localparam int QB  = $clog2(GRID_SIZE);
    localparam int C   = FRACTION_BITS + 6;
    localparam int NW  = FRACTION_BITS + 16;
    localparam int WW  = FRACTION_BITS + 8;
    localparam int LAT = 6 + QB;

    // ---- configuration registers ----
    logic [ANGLE_BITS-1:0] angle_a_reg, angle_b_reg;
    logic [TUBE_W-1:0]     tube_reg;
    logic [RING_W-1:0]     ring_reg;
    logic [VIEW_W-1:0]     view_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [CENTER_W-1:0]   ccol_reg, crow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_a_reg <= '0;
            angle_b_reg <= '0;
            tube_reg    <= TUBE_RESET;
            ring_reg    <= RING_RESET;
            view_reg    <= VIEW_RESET;
            scale_reg   <= SCALE_RESET;
            ccol_reg    <= CCOL_RESET;
            crow_reg    <= CROW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ANGLE_A:     angle_a_reg <= cfg_data;
                CFG_ANGLE_B:     angle_b_reg <= cfg_data;
                CFG_TUBE_RADIUS: tube_reg    <= cfg_data[TUBE_W-1:0];
                CFG_RING_RADIUS: ring_reg    <= cfg_data[RING_W-1:0];
                CFG_VIEWER_DIST: view_reg    <= cfg_data[VIEW_W-1:0];
                CFG_PROJ_SCALE:  scale_reg   <= cfg_data[SCALE_W-1:0];
                CFG_CENTER_COL:  ccol_reg    <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_ROW:  crow_reg    <= cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- pipeline control: advance unless the output register is blocked ----
    logic           pipe_en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign pipe_en  = !vld_reg[LAT-1] || m_ready;
    assign s_ready  = pipe_en;
    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // ---- stage 1: trig lookup ----
    trig_t trig;

    tpps_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_theta (
        .aclk(aclk), .en(pipe_en), .angle(s_theta),
        .sin_out(trig.sin_theta), .cos_out(trig.cos_theta)
    );
    tpps_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_phi (
        .aclk(aclk), .en(pipe_en), .angle(s_phi),
        .sin_out(trig.sin_phi), .cos_out(trig.cos_phi)
    );
    tpps_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_a (
        .aclk(aclk), .en(pipe_en), .angle(angle_a_reg),
        .sin_out(trig.sin_a), .cos_out(trig.cos_a)
    );
    tpps_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_b (
        .aclk(aclk), .en(pipe_en), .angle(angle_b_reg),
        .sin_out(trig.sin_b), .cos_out(trig.cos_b)
    );

    // ---- stages 2 to 4: rotation and shading ----
    logic signed [C-1:0] x3, y3, z3;
    logic [GLYPH_W-1:0]  glyph4;

    tpps_geom #(.FRACTION_BITS(FRACTION_BITS)) u_geom (
        .aclk        (aclk),
        .en          (pipe_en),
        .trig        (trig),
        .tube_radius (tube_reg),
        .ring_radius (ring_reg),
        .x3          (x3),
        .y3          (y3),
        .z3          (z3),
        .glyph       (glyph4)
    );

    // ---- stages 5 and 6: projection setup ----
    logic [NW-2:0]      col_num, row_num;
    logic [WW-2:0]      depth;
    logic               col_ok, row_ok;
    logic [GLYPH_W-1:0] glyph6;

    tpps_proj #(.FRACTION_BITS(FRACTION_BITS), .GRID_SIZE(GRID_SIZE)) u_proj (
        .aclk             (aclk),
        .en               (pipe_en),
        .x3               (x3),
        .y3               (y3),
        .z3               (z3),
        .glyph_in         (glyph4),
        .viewer_distance  (view_reg),
        .projection_scale (scale_reg),
        .center_col       (ccol_reg),
        .center_row       (crow_reg),
        .col_num          (col_num),
        .row_num          (row_num),
        .depth            (depth),
        .col_ok           (col_ok),
        .row_ok           (row_ok),
        .glyph_out        (glyph6)
    );

    // ---- quotient pipelines ----
    logic [QB-1:0] col_q, row_q;
    logic          col_fin_ok, row_fin_ok;

    tpps_div #(.NUM_W(NW-1), .DEN_W(WW-1), .QUO_W(QB)) u_div_col (
        .aclk(aclk), .en(pipe_en), .num(col_num), .den(depth), .ok_in(col_ok),
        .quo(col_q), .ok_out(col_fin_ok)
    );
    tpps_div #(.NUM_W(NW-1), .DEN_W(WW-1), .QUO_W(QB)) u_div_row (
        .aclk(aclk), .en(pipe_en), .num(row_num), .den(depth), .ok_in(row_ok),
        .quo(row_q), .ok_out(row_fin_ok)
    );

    // glyph rides alongside the divider stages
    logic [GLYPH_W-1:0] glyph_dly_reg [QB];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            glyph_dly_reg[0] <= glyph6;
            for (int i = 1; i < QB; i++) begin
                glyph_dly_reg[i] <= glyph_dly_reg[i-1];
            end
        end
    end

    logic plot;

    assign plot          = col_fin_ok && row_fin_ok;
    assign m_valid       = vld_reg[LAT-1];
    assign m_plotted     = plot;
    assign m_column      = plot ? col_q : '0;
    assign m_row         = plot ? row_q : '0;
    assign m_glyph_index = glyph_dly_reg[QB-1];

endmodule

[hw/rtl/tpps_sincos.sv]
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// Quarter-wave Q1.15 table folded over four quadrants, registered output.
// ----------------------------------------------------------------------------
module tpps_sincos #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [ANGLE_BITS-1:0]  angle,
    output tpps_pkg::q15_t         sin_out,
    output tpps_pkg::q15_t         cos_out
);
    import tpps_pkg::*;

    localparam int QN = 2 ** (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-2:0] QN_IDX = (ANGLE_BITS-1)'(QN);

    typedef logic [14:0] qtab_t [0:QN];

    // Fixed-point Taylor series to x^13, rounded to Q1.15
    function automatic qtab_t build_qtab();
        qtab_t           t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tt;
        longint          s;
        for (int kk = 0; kk <= QN; kk++) begin
            x  = (longint'(kk) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            tt = x;
            s  = longint'(x);
            // terms alternate in sign; divisors are (2n)(2n+1) for n = 1..6
            tt = ((tt * x2) >> 30) / 64'd6;
            s  = s - longint'(tt);
            tt = ((tt * x2) >> 30) / 64'd20;
            s  = s + longint'(tt);
            tt = ((tt * x2) >> 30) / 64'd42;
            s  = s - longint'(tt);
            tt = ((tt * x2) >> 30) / 64'd72;
            s  = s + longint'(tt);
            tt = ((tt * x2) >> 30) / 64'd110;
            s  = s - longint'(tt);
            tt = ((tt * x2) >> 30) / 64'd156;
            s  = s + longint'(tt);
            if (s < 0) begin
                s = 0;
            end
            s = (s + 64'sd16384) >>> 15;
            if (s > 32767) begin
                s = 32767;
            end
            t[kk] = s[14:0];
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    function automatic logic [ANGLE_BITS-2:0] fold(input logic [1:0] q,
                                                   input logic [ANGLE_BITS-3:0] k);
        return q[0] ? (QN_IDX - {1'b0, k}) : {1'b0, k};
    endfunction

    logic [1:0]            quad_s;
    logic [1:0]            quad_c;
    logic [ANGLE_BITS-3:0] k;
    logic [14:0]           mag_s;
    logic [14:0]           mag_c;
    q15_t                  sin_next;
    q15_t                  cos_next;
    q15_t                  sin_reg;
    q15_t                  cos_reg;

    assign quad_s = angle[ANGLE_BITS-1 -: 2];
    assign quad_c = quad_s + 2'd1;
    assign k      = angle[ANGLE_BITS-3:0];
    assign mag_s  = QTAB[fold(quad_s, k)];
    assign mag_c  = QTAB[fold(quad_c, k)];

    always_comb begin
        sin_next = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
        cos_next = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

[hw/rtl/tpps_geom.sv]
// ----------------------------------------------------------------------------
// Rotation and shading
// Three stages: surface point and first trig products, second-level
// products, then rotated X3/Y3/Z3 and the glyph index.
// ----------------------------------------------------------------------------
module tpps_geom #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              en,
    input  tpps_pkg::trig_t                   trig,
    input  logic [tpps_pkg::TUBE_W-1:0]       tube_radius,
    input  logic [tpps_pkg::RING_W-1:0]       ring_radius,
    output logic signed [FRACTION_BITS+5:0]   x3,
    output logic signed [FRACTION_BITS+5:0]   y3,
    output logic signed [FRACTION_BITS+5:0]   z3,
    output logic [tpps_pkg::GLYPH_W-1:0]      glyph
);
    import tpps_pkg::*;

    localparam int C  = FRACTION_BITS + 6;
    localparam int PW = C + 18;
    localparam logic signed [PW-1:0] RND       = PW'(32767);
    localparam logic signed [PW-1:0] COORD_MAX = PW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] COORD_MIN = -COORD_MAX - PW'(1);

    function automatic logic signed [PW-1:0] tsh15(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] b;
        b = v + (v[PW-1] ? RND : '0);
        return b >>> 15;
    endfunction

    function automatic logic signed [C-1:0] sat_c(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = v;
        if (v > COORD_MAX) begin
            r = COORD_MAX;
        end else if (v < COORD_MIN) begin
            r = COORD_MIN;
        end
        return r[C-1:0];
    endfunction

    // ---- stage 2: surface point, first products ----
    logic signed [19:0]   tube_cth;
    logic signed [19:0]   tube_sth;
    logic signed [PW-1:0] ring_fix;
    logic signed [PW-1:0] tube_cfix;
    logic signed [PW-1:0] tube_sfix;
    logic signed [C-1:0]  x_next;
    logic signed [C-1:0]  y_next;

    q15w_t sth, cth, sph, cph, sa, ca, sb, cb;

    assign sth = q15w_t'(trig.sin_theta);
    assign cth = q15w_t'(trig.cos_theta);
    assign sph = q15w_t'(trig.sin_phi);
    assign cph = q15w_t'(trig.cos_phi);
    assign sa  = q15w_t'(trig.sin_a);
    assign ca  = q15w_t'(trig.cos_a);
    assign sb  = q15w_t'(trig.sin_b);
    assign cb  = q15w_t'(trig.cos_b);

    assign tube_cth  = $signed({1'b0, tube_radius}) * cth;
    assign tube_sth  = $signed({1'b0, tube_radius}) * sth;
    assign ring_fix  = $signed(PW'(ring_radius)) <<< FRACTION_BITS;
    assign tube_cfix = PW'(tube_cth) <<< FRACTION_BITS;
    assign tube_sfix = PW'(tube_sth) <<< FRACTION_BITS;
    assign x_next    = sat_c(ring_fix + tsh15(tube_cfix));
    assign y_next    = sat_c(tsh15(tube_sfix));

    logic signed [C-1:0] x2_reg, y2_reg;
    q15w_t cbcph_reg, sasb_reg, cphsb_reg, cbsa_reg, casb_reg, cacb_reg, casph_reg;
    q15w_t cphcth_reg, cacth_reg, sasth_reg, casth_reg, cthsa_reg;
    q15w_t sa2_reg, sph2_reg, cb2_reg, sb2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg     <= x_next;
            y2_reg     <= y_next;
            cbcph_reg  <= mul_q15(cb, cph);
            sasb_reg   <= mul_q15(sa, sb);
            cphsb_reg  <= mul_q15(cph, sb);
            cbsa_reg   <= mul_q15(cb, sa);
            casb_reg   <= mul_q15(ca, sb);
            cacb_reg   <= mul_q15(ca, cb);
            casph_reg  <= mul_q15(ca, sph);
            cphcth_reg <= mul_q15(cph, cth);
            cacth_reg  <= mul_q15(ca, cth);
            sasth_reg  <= mul_q15(sa, sth);
            casth_reg  <= mul_q15(ca, sth);
            cthsa_reg  <= mul_q15(cth, sa);
            sa2_reg    <= sa;
            sph2_reg   <= sph;
            cb2_reg    <= cb;
            sb2_reg    <= sb;
        end
    end

    // ---- stage 3: rotation factors and light terms ----
    logic signed [C-1:0] x3s_reg, y3s_reg;
    q15w_t p1_reg, p2_reg, casb3_reg, cacb3_reg, casph3_reg, sa3_reg, cb3_reg;
    q15w_t l1_reg, l2_reg, l3_reg, inner_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x3s_reg    <= x2_reg;
            y3s_reg    <= y2_reg;
            p1_reg     <= cbcph_reg + mul_q15(sasb_reg, sph2_reg);
            p2_reg     <= cphsb_reg - mul_q15(cbsa_reg, sph2_reg);
            casb3_reg  <= casb_reg;
            cacb3_reg  <= cacb_reg;
            casph3_reg <= casph_reg;
            sa3_reg    <= sa2_reg;
            cb3_reg    <= cb2_reg;
            l1_reg     <= mul_q15(cphcth_reg, sb2_reg);
            l2_reg     <= mul_q15(cacth_reg, sph2_reg);
            l3_reg     <= sasth_reg;
            inner_reg  <= casth_reg - mul_q15(cthsa_reg, sph2_reg);
        end
    end

    // ---- stage 4: rotated coordinates and glyph ----
    logic signed [PW-1:0] x_p1, y_casb, x_p2, y_cacb, x_casph, y_sa;
    logic signed [C-1:0]  x3_next, y3_next, z3_next;
    q15w_t                l5;
    logic signed [19:0]   lsum;
    logic signed [23:0]   lgain;
    logic signed [23:0]   lraw;
    logic [GLYPH_W-1:0]   glyph_next;

    assign x_p1    = x3s_reg * p1_reg;
    assign y_casb  = y3s_reg * casb3_reg;
    assign x_p2    = x3s_reg * p2_reg;
    assign y_cacb  = y3s_reg * cacb3_reg;
    assign x_casph = x3s_reg * casph3_reg;
    assign y_sa    = y3s_reg * sa3_reg;
    assign x3_next = sat_c(tsh15(x_p1) - tsh15(y_casb));
    assign y3_next = sat_c(tsh15(x_p2) + tsh15(y_cacb));
    assign z3_next = sat_c(tsh15(x_casph) + tsh15(y_sa));

    assign l5    = mul_q15(cb3_reg, inner_reg);
    assign lsum  = 20'(l1_reg) - 20'(l2_reg) - 20'(l3_reg) + 20'(l5);
    assign lgain = 24'(lsum) <<< LIGHT_SHIFT;
    assign lraw  = (lgain + (lgain[23] ? 24'sd32767 : 24'sd0)) >>> 15;

    always_comb begin
        if (lraw <= 24'sd0) begin
            glyph_next = '0;
        end else if (lraw > 24'(GLYPH_MAX)) begin
            glyph_next = GLYPH_MAX;
        end else begin
            glyph_next = lraw[GLYPH_W-1:0];
        end
    end

    logic signed [C-1:0] x3_reg, y3_reg, z3_reg;
    logic [GLYPH_W-1:0]  glyph_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x3_reg    <= x3_next;
            y3_reg    <= y3_next;
            z3_reg    <= z3_next;
            glyph_reg <= glyph_next;
        end
    end

    assign x3    = x3_reg;
    assign y3    = y3_reg;
    assign z3    = z3_reg;
    assign glyph = glyph_reg;

endmodule

[hw/rtl/tpps_proj.sv]
// ----------------------------------------------------------------------------
// Perspective setup
// Depth w and the column/row numerators, then the grid range test and the
// operands for the quotient pipelines.
// ----------------------------------------------------------------------------
module tpps_proj #(
    parameter int FRACTION_BITS = 16,
    parameter int GRID_SIZE     = 100
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [FRACTION_BITS+5:0]    x3,
    input  logic signed [FRACTION_BITS+5:0]    y3,
    input  logic signed [FRACTION_BITS+5:0]    z3,
    input  logic [tpps_pkg::GLYPH_W-1:0]       glyph_in,
    input  logic [tpps_pkg::VIEW_W-1:0]        viewer_distance,
    input  logic [tpps_pkg::SCALE_W-1:0]       projection_scale,
    input  logic [tpps_pkg::CENTER_W-1:0]      center_col,
    input  logic [tpps_pkg::CENTER_W-1:0]      center_row,
    output logic [FRACTION_BITS+14:0]          col_num,
    output logic [FRACTION_BITS+14:0]          row_num,
    output logic [FRACTION_BITS+6:0]           depth,
    output logic                               col_ok,
    output logic                               row_ok,
    output logic [tpps_pkg::GLYPH_W-1:0]       glyph_out
);
    import tpps_pkg::*;

    localparam int WW = FRACTION_BITS + 8;
    localparam int NW = FRACTION_BITS + 16;

    // ---- stage 5: depth and numerators ----
    logic signed [WW-1:0] vd_fix;
    logic signed [WW-1:0] w_next;
    logic signed [NW-1:0] cc_w, s_x3, cr_w, s_y3;

    assign vd_fix = $signed(WW'(viewer_distance)) <<< FRACTION_BITS;
    assign w_next = WW'(z3) + vd_fix;
    assign cc_w   = $signed(NW'(center_col)) * NW'(w_next);
    assign s_x3   = $signed(NW'(projection_scale)) * NW'(x3);
    assign cr_w   = $signed(NW'(center_row)) * NW'(w_next);
    assign s_y3   = $signed(NW'(projection_scale)) * NW'(y3);

    logic signed [WW-1:0] w_reg;
    logic signed [NW-1:0] numc_reg, numr_reg;
    logic [GLYPH_W-1:0]   glyph5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg      <= w_next;
            numc_reg   <= cc_w + s_x3;
            numr_reg   <= cr_w + s_y3;
            glyph5_reg <= glyph_in;
        end
    end

    // ---- stage 6: range test; a negative numerator truncates to zero ----
    logic signed [NW-1:0] w_ext, grid_w, negc, negr;
    logic                 w_pos, okc_next, okr_next;

    assign w_ext  = NW'(w_reg);
    assign grid_w = $signed(NW'(GRID_SIZE)) * w_ext;
    assign negc   = -numc_reg;
    assign negr   = -numr_reg;
    assign w_pos  = !w_reg[WW-1] && (w_reg != '0);

    always_comb begin
        okc_next = w_pos && (numc_reg[NW-1] ? (negc < w_ext) : (numc_reg < grid_w));
        okr_next = w_pos && (numr_reg[NW-1] ? (negr < w_ext) : (numr_reg < grid_w));
    end

    logic [NW-2:0]      divc_reg, divr_reg;
    logic [WW-2:0]      den_reg;
    logic               okc_reg, okr_reg;
    logic [GLYPH_W-1:0] glyph6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            divc_reg   <= numc_reg[NW-1] ? '0 : numc_reg[NW-2:0];
            divr_reg   <= numr_reg[NW-1] ? '0 : numr_reg[NW-2:0];
            den_reg    <= w_reg[WW-2:0];
            okc_reg    <= okc_next;
            okr_reg    <= okr_next;
            glyph6_reg <= glyph5_reg;
        end
    end

    assign col_num   = divc_reg;
    assign row_num   = divr_reg;
    assign depth     = den_reg;
    assign col_ok    = okc_reg;
    assign row_ok    = okr_reg;
    assign glyph_out = glyph6_reg;

endmodule

[hw/rtl/tpps_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first; the in-range flag
// travels alongside.
// ----------------------------------------------------------------------------
module tpps_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 23,
    parameter int QUO_W = 7
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             ok_in,
    output logic [QUO_W-1:0] quo,
    output logic             ok_out
);
    localparam int EW = NUM_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic             ok_reg  [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - 1 - j;

        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic             ok_i;
        logic [EW-1:0]    den_sh;
        logic             take;
        logic [QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign ok_i   = ok_in;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign ok_i   = ok_reg[j-1];
        end

        assign den_sh = EW'(den_in) << B;
        assign take   = (EW'(rem_in) >= den_sh);

        always_comb begin
            quo_next    = quo_in;
            quo_next[B] = take;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[j] <= quo_next;
                ok_reg[j]  <= ok_i;
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? (rem_in - den_sh[NUM_W-1:0]) : rem_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo    = quo_reg[QUO_W-1];
    assign ok_out = ok_reg[QUO_W-1];

endmodule

[hw/rtl/tpps_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the torus point projector
// Watches the result channel for reset behavior, unplotted-point origin, grid
// bounds, shading range and results held under a stall.
// ----------------------------------------------------------------------------
module tpps_checker #(
    parameter int GRID_SIZE = 100
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [$clog2(GRID_SIZE)-1:0]       m_column,
    input logic [$clog2(GRID_SIZE)-1:0]       m_row,
    input logic [tpps_pkg::GLYPH_W-1:0]       m_glyph_index,
    input logic                               m_plotted
);
    import tpps_pkg::*;

    localparam int QB = $clog2(GRID_SIZE);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an unplotted point reports the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_plotted) |-> (m_column == '0 && m_row == '0))
        else $error("unplotted point with nonzero position");

    // a plotted point lies on the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_plotted) |->
            (m_column < QB'(GRID_SIZE - 1) || m_column == QB'(GRID_SIZE - 1)) &&
            (m_row < QB'(GRID_SIZE - 1) || m_row == QB'(GRID_SIZE - 1)))
        else $error("plotted point off the grid");

    // shade stays on the ramp
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_glyph_index <= GLYPH_MAX))
        else $error("glyph index beyond ramp");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_column) && $stable(m_row)
                                   && $stable(m_glyph_index) && $stable(m_plotted)))
        else $error("stalled result changed");

endmodule

bind torus_point_project_shade tpps_checker #(.GRID_SIZE(GRID_SIZE)) u_tpps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_column      (m_column),
    .m_row         (m_row),
    .m_glyph_index (m_glyph_index),
    .m_plotted     (m_plotted)
);
